// ===== design/lcb_pkg.sv =====
// Package for the LRU frame cache with byte budget.
// Holds request and result codes, the capacity and the row command type.
// No dependencies.
package lcb_pkg;
   // Number of cells in the row, which is the most entries ever resident.
   localparam int MAX_ENTRIES = 16;

   localparam logic [1:0] REQ_GET    = 2'd0;
   localparam logic [1:0] REQ_PUT    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic [1:0] KIND_DONE    = 2'd0;
   localparam logic [1:0] KIND_EVICT   = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   localparam logic CSR_MAX_ENTRIES = 1'b0;
   localparam logic CSR_BYTE_BUDGET = 1'b1;

   // Command broadcast from the controller to the cell row.
   typedef struct packed {
      logic shift;   // every cell takes its upstream neighbor's contents
      logic clear;   // invalidate every cell
      logic drop;    // remove the matching cell and close the gap
      logic touch;   // move the matching cell to the front
      logic evict;   // invalidate the oldest occupied cell
   } row_cmd_type;
endpackage

// ===== design/lcb_cell.sv =====
// One cell of the recency-ordered row: valid bit, tag and size.
// Depends on lcb_pkg. Cell 0 is the most recent position.
module lcb_cell (
   input  logic                clock,
   input  logic                reset,
   input  lcb_pkg::row_cmd_type cmd,
   input  logic [30:0]         key,
   input  logic                hit_above,  // a match exists at a lower position
   input  logic                hit_below,  // a match exists at a higher position
   input  logic                up_valid,
   input  logic [30:0]         up_tag,
   input  logic [31:0]         up_size,
   input  logic                dn_valid,
   input  logic [30:0]         dn_tag,
   input  logic [31:0]         dn_size,
   output logic                valid,
   output logic [30:0]         tag,
   output logic [31:0]         size,
   output logic                hit
);
   logic        valid_ff, valid_in;
   logic [30:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;

   assign hit   = valid_ff && (tag_ff == key);
   assign valid = valid_ff;
   assign tag   = tag_ff;
   assign size  = size_ff;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      size_in  = size_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.shift) begin
         valid_in = up_valid;
         tag_in   = up_tag;
         size_in  = up_size;
      end else if (cmd.drop && (hit || hit_above)) begin
         // the gap closes by pulling older cells forward
         valid_in = dn_valid;
         tag_in   = dn_tag;
         size_in  = dn_size;
      end else if (cmd.touch && (hit || hit_below)) begin
         // cells up to the hit move back one place; cell 0 is loaded by the top
         valid_in = up_valid;
         tag_in   = up_tag;
         size_in  = up_size;
      end else if (cmd.evict && !dn_valid) begin
         // the last occupied cell and the empty cells behind it end up empty
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff  <= tag_in;
      size_ff <= size_in;
   end
endmodule

// ===== design/lcb_row.sv =====
// Row of lcb_cell instances kept in recency order, front first.
// Depends on lcb_pkg and lcb_cell.
module lcb_row #(
   parameter int N = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  lcb_pkg::row_cmd_type cmd,
   input  logic [30:0]         key,
   input  logic [30:0]         front_tag,
   input  logic [31:0]         front_size,
   output logic                any_hit,
   output logic [31:0]         hit_size,
   output logic                last_valid,
   output logic [30:0]         oldest_tag,
   output logic [31:0]         oldest_size
);
   logic [N-1:0]  v, h, above, below, tail;
   logic [30:0]   t [N];
   logic [31:0]   s [N];

   // Occupied cells are packed at the front, so the oldest entry is the
   // single valid cell whose downstream neighbor is empty.
   assign tail = v & ~{1'b0, v[N-1:1]};

   always_comb begin
      above[0] = 1'b0;
      for (int i = 1; i < N; i++) above[i] = above[i-1] | h[i-1];
      below[N-1] = 1'b0;
      for (int i = N - 2; i >= 0; i--) below[i] = below[i+1] | h[i+1];
      hit_size    = '0;
      oldest_tag  = '0;
      oldest_size = '0;
      for (int i = 0; i < N; i++) if (h[i]) hit_size = s[i];
      for (int i = 0; i < N; i++) begin
         if (tail[i]) begin
            oldest_tag  = t[i];
            oldest_size = s[i];
         end
      end
   end
   assign any_hit = |h;

   assign last_valid = v[N-1];

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic        uv, dv;
      logic [30:0] ut, dt;
      logic [31:0] us, ds;
      if (i == 0) begin : g_front
         assign uv = 1'b1;
         assign ut = front_tag;
         assign us = front_size;
      end else begin : g_mid
         assign uv = v[i-1];
         assign ut = t[i-1];
         assign us = s[i-1];
      end
      if (i == N - 1) begin : g_back
         assign dv = 1'b0;
         assign dt = '0;
         assign ds = '0;
      end else begin : g_nxt
         assign dv = v[i+1];
         assign dt = t[i+1];
         assign ds = s[i+1];
      end
      lcb_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .key(key),
         .hit_above(above[i]), .hit_below(below[i]),
         .up_valid(uv), .up_tag(ut), .up_size(us),
         .dn_valid(dv), .dn_tag(dt), .dn_size(ds),
         .valid(v[i]), .tag(t[i]), .size(s[i]), .hit(h[i])
      );
   end
endmodule

// ===== design/lru_cache_with_byte_budget.sv =====
// LRU frame cache under an entry limit and a byte budget, built as a row of cells.
// A get, remove, clear or refused put passes through the execute and output states;
// a stored put also passes through the eviction state, once per eviction and once
// more, and then the insert state; a waiting result that stays stalled holds it up.
// The next transaction is accepted only after the final result is loaded.
// Reset (synchronous, active high) empties the row and restores the limits
// to 16 entries and 268435456 bytes. There is no clearing pass.
module lru_cache_with_byte_budget (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [30:0] req_frame_number,
   input  logic [31:0] req_frame_size_bytes,
   input  logic        req_samples_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [30:0] rsp_result_frame,
   output logic        rsp_found,
   output logic [4:0]  rsp_resident_count,
   output logic [39:0] rsp_resident_bytes,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [39:0] csr_data
);
   // The row is kept in recency order: cell 0 is the most recent entry and
   // the valid entries stay packed at positions 0 to count-1. A drop closes
   // the gap, a touch rotates the hit to the front, an insert shifts the whole
   // row back by one, and an eviction invalidates the last occupied cell. The
   // row reports the oldest entry's tag and size so an eviction needs no index.
   localparam int MAX_ENTRIES = lcb_pkg::MAX_ENTRIES;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_EVICT = 3'd2;
   localparam logic [2:0] ST_INS   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  max_ff;
   logic [39:0] budget_ff;
   logic [1:0]  op_ff;
   logic [30:0] tag_ff;
   logic [31:0] size_ff;
   logic        ok_ff;
   logic        found_ff, found_in;
   logic [CW-1:0] count_ff, count_in;
   logic [39:0] bytes_ff, bytes_in;
   logic        rv_ff, rv_in;
   logic [1:0]  rk_ff, rk_in;
   logic [30:0] rf_ff, rf_in;
   logic        rfd_ff, rfd_in;
   logic [39:0] rb_ff, rb_in;
   logic [CW-1:0] rc_ff, rc_in;
   logic        rl_ff, rl_in;

   lcb_pkg::row_cmd_type cmd;
   logic        any_hit, last_valid;
   logic [31:0] hit_size;
   logic [30:0] evict_tag;
   logic [31:0] evict_size;
   logic [31:0] front_size;

   // A touched entry keeps its own size when it moves to the front; an
   // inserted entry brings the size of the put.
   assign front_size = cmd.touch ? hit_size : size_ff;

   lcb_row #(.N(MAX_ENTRIES)) u_row (
      .clock(clock), .reset(reset), .cmd(cmd), .key(tag_ff),
      .front_tag(tag_ff), .front_size(front_size),
      .any_hit(any_hit), .hit_size(hit_size),
      .last_valid(last_valid), .oldest_tag(evict_tag), .oldest_size(evict_size)
   );

   logic [4:0]  limit;
   logic        refuse, over;
   logic [40:0] sum_bytes;
   assign limit = (max_ff > 5'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES) : max_ff;
   assign refuse = (limit == 5'd0) || (budget_ff == 40'd0) || !ok_ff ||
                   (size_ff == 32'd0) || ({8'd0, size_ff} > budget_ff);
   assign sum_bytes = {1'b0, bytes_ff} + {9'd0, size_ff};
   assign over = (count_ff != '0) &&
                 ((5'(count_ff) + 5'd1 > limit) || (sum_bytes > {1'b0, budget_ff}));

   function automatic logic [39:0] sub_floor(input logic [39:0] a, input logic [31:0] b);
      sub_floor = ({8'd0, b} < a) ? a - {8'd0, b} : 40'd0;
   endfunction

   // A waiting final result does not hold off the next request: the result
   // register is only reloaded once it has been taken.
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= 5'd16;
         budget_ff <= 40'd268435456;
      end else if (csr_valid) begin
         unique case (csr_index)
            lcb_pkg::CSR_MAX_ENTRIES: max_ff    <= csr_data[4:0];
            lcb_pkg::CSR_BYTE_BUDGET: budget_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      found_in = found_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      rv_in = rv_ff && rsp_stall;
      rk_in = rk_ff; rf_in = rf_ff; rfd_in = rfd_ff;
      rb_in = rb_ff; rc_in = rc_ff; rl_in = rl_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && !req_stall) state_in = ST_EXEC;
         ST_EXEC: begin
            found_in = any_hit;
            unique case (op_ff) inside
               lcb_pkg::REQ_GET: begin
                  cmd.touch = any_hit;
                  state_in = ST_OUT;
               end
               lcb_pkg::REQ_REMOVE, lcb_pkg::REQ_PUT: begin
                  // A resident copy leaves first, also for a refused put.
                  if (any_hit) begin
                     cmd.drop = 1'b1;
                     count_in = count_ff - CW'(1);
                     bytes_in = sub_floor(bytes_ff, hit_size);
                  end
                  if (op_ff == lcb_pkg::REQ_REMOVE) state_in = ST_OUT;
                  else if (refuse) begin
                     state_in = ST_OUT;
                  end else state_in = ST_EVICT;
               end
               lcb_pkg::REQ_CLEAR: begin
                  cmd.clear = 1'b1;
                  count_in = '0;
                  bytes_in = '0;
                  found_in = 1'b0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_EVICT: if (!rv_ff || !rsp_stall) begin
            // One oldest entry leaves per cycle while no result waits stalled, until the new
            // one fits; the reported totals already include the entry being put.
            if (over) begin
               cmd.evict = 1'b1;
               count_in = count_ff - CW'(1);
               bytes_in = sub_floor(bytes_ff, evict_size);
               rv_in = 1'b1; rk_in = lcb_pkg::KIND_EVICT; rf_in = evict_tag;
               rfd_in = 1'b0; rl_in = 1'b0;
               rc_in = count_ff;
               rb_in = sub_floor(bytes_ff, evict_size) + {8'd0, size_ff};
            end else state_in = ST_INS;
         end
         ST_INS: begin
            cmd.shift = 1'b1;
            count_in = count_ff + CW'(1);
            bytes_in = sum_bytes[39:0];
            state_in = ST_OUT;
         end
         ST_OUT: if (!rv_ff || !rsp_stall) begin
            rv_in = 1'b1;
            rk_in = (op_ff == lcb_pkg::REQ_PUT && refuse) ? lcb_pkg::KIND_REFUSED
                                                         : lcb_pkg::KIND_DONE;
            rf_in = tag_ff; rfd_in = found_ff; rl_in = 1'b1;
            rc_in = count_ff; rb_in = bytes_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         bytes_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         rv_ff    <= rv_in;
      end
      found_ff <= found_in;
      rk_ff <= rk_in; rf_ff <= rf_in; rfd_ff <= rfd_in;
      rb_ff <= rb_in; rc_ff <= rc_in; rl_ff <= rl_in;
      if (state_ff == ST_IDLE && req_valid && !req_stall) begin
         op_ff   <= req_type;
         tag_ff  <= req_frame_number;
         size_ff <= req_frame_size_bytes;
         ok_ff   <= req_samples_ok;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_result_kind    = rk_ff;
   assign rsp_result_frame   = rf_ff;
   assign rsp_found          = rfd_ff;
   assign rsp_resident_count = 5'(rc_ff);
   assign rsp_resident_bytes = rb_ff;
   assign rsp_last_result    = rl_ff;

   a_back_cell: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'(MAX_ENTRIES)) |-> last_valid)
      else $error("back cell empty while row is full");
   a_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |-> !last_valid)
      else $error("insert would push an entry off the back");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("entry count out of range");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=>
      (rv_ff && $stable({rk_ff, rf_ff, rfd_ff, rc_ff, rb_ff, rl_ff})))
      else $error("result dropped or changed under stall");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for lru_cache_with_byte_budget: directed and random
// request streams, checked against an in-bench model of the LRU cache.
// Depends on lcb_pkg and the lru_cache_with_byte_budget RTL.
`timescale 1ns / 1ps
module tb;
   localparam int SLOTS = lcb_pkg::MAX_ENTRIES;
   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = lcb_pkg::REQ_GET;
   logic [30:0] req_frame_number = '0;
   logic [31:0] req_frame_size_bytes = '0;
   logic        req_samples_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [30:0] rsp_result_frame;
   logic        rsp_found;
   logic [4:0]  rsp_resident_count;
   logic [39:0] rsp_resident_bytes;
   logic        rsp_last_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = lcb_pkg::CSR_MAX_ENTRIES;
   logic [39:0] csr_data = '0;

   lru_cache_with_byte_budget dut (.*);

   // The clock runs with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // One expected result transaction of the cache.
   typedef struct {
      logic [1:0]  kind;
      logic [30:0] frame;
      logic        found;
      logic [4:0]  count;
      logic [39:0] bytes;
      logic        last;
   } cache_result_type;

   cache_result_type pending_results[$];

   // Model of the cache contents and of its two limit registers.
   logic [4:0]  lim_entries;
   logic [39:0] lim_bytes;
   bit          slot_used[SLOTS];
   logic [30:0] slot_frame[SLOTS];
   logic [31:0] slot_bytes[SLOTS];
   int          slot_age[SLOTS];
   logic [39:0] held_bytes;
   int          held_count;

   int errors = 0;
   int reqs_sent = 0;
   int results_seen = 0;
   int evictions_seen = 0;
   int refusals_seen = 0;
   int idle_cycles = 0;
   bit no_idling = 1'b0;

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic int find_frame(input logic [30:0] frame);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_frame[i] == frame)
            return i;
      return -1;
   endfunction

   // Removing an entry closes the gap in the age order behind it.
   task automatic drop_entry(input int s);
      int r;
      r = slot_age[s];
      held_bytes = (slot_bytes[s] < held_bytes) ? held_bytes - slot_bytes[s] : '0;
      slot_used[s] = 1'b0;
      if (held_count > 0)
         held_count--;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_age[i] > r)
            slot_age[i]--;
   endtask

   task automatic touch_entry(input int s);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_age[i] < slot_age[s])
            slot_age[i]++;
      slot_age[s] = 0;
   endtask

   function automatic int oldest_entry();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && (best < 0 || slot_age[i] > slot_age[best]))
            best = i;
      return best;
   endfunction

   task automatic push_result(input logic [1:0] kind, input logic [30:0] frame,
                              input logic found, input int count,
                              input logic [39:0] bytes, input logic last);
      cache_result_type r;
      r.kind = kind;
      r.frame = frame;
      r.found = found;
      r.count = count[4:0];
      r.bytes = bytes;
      r.last = last;
      pending_results.push_back(r);
   endtask

   // Works out the results of one accepted request and updates the model.
   task automatic predict_cache(input logic [1:0] op, input logic [30:0] frame,
                                input logic [31:0] size, input logic ok);
      int s;
      int v;
      int lim;
      int free_slot;
      logic found;
      s = find_frame(frame);
      found = (s >= 0);
      lim = (lim_entries > SLOTS) ? SLOTS : lim_entries;
      case (op)
         lcb_pkg::REQ_GET: begin
            if (s >= 0)
               touch_entry(s);
         end
         lcb_pkg::REQ_REMOVE: begin
            if (s >= 0)
               drop_entry(s);
         end
         lcb_pkg::REQ_CLEAR: begin
            for (int i = 0; i < SLOTS; i++)
               slot_used[i] = 1'b0;
            held_bytes = '0;
            held_count = 0;
            found = 1'b0;
         end
         default: begin
            if (lim == 0 || lim_bytes == 0 || !ok || size == 0 || 40'(size) > lim_bytes) begin
               if (s >= 0)
                  drop_entry(s);
               push_result(lcb_pkg::KIND_REFUSED, frame, found, held_count, held_bytes,
                           1'b1);
               return;
            end
            if (s >= 0)
               drop_entry(s);
            // Oldest entries leave until the new frame fits both limits.
            while (held_count > 0 && (held_count + 1 > lim ||
                   ({1'b0, held_bytes} + 41'(size)) > {1'b0, lim_bytes})) begin
               v = oldest_entry();
               if (v < 0)
                  break;
               drop_entry(v);
               push_result(lcb_pkg::KIND_EVICT, slot_frame[v], 1'b0, held_count + 1,
                           held_bytes + 40'(size), 1'b0);
            end
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
               if (!slot_used[i] && free_slot < 0)
                  free_slot = i;
            if (free_slot >= 0) begin
               for (int j = 0; j < SLOTS; j++)
                  if (slot_used[j])
                     slot_age[j]++;
               slot_used[free_slot] = 1'b1;
               slot_frame[free_slot] = frame;
               slot_bytes[free_slot] = size;
               slot_age[free_slot] = 0;
               held_count++;
               held_bytes = held_bytes + 40'(size);
            end
         end
      endcase
      push_result(lcb_pkg::KIND_DONE, frame, found, held_count, held_bytes, 1'b1);
   endtask

   function automatic int draw_gap();
      return no_idling ? 0 : $urandom_range(0, 15);
   endfunction

   // Sends one request transaction. Valid stays high across back-to-back
   // requests and is only lowered when a gap is drawn.
   task automatic send_req(input logic [1:0] op, input logic [30:0] frame,
                           input logic [31:0] size, input logic ok);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_frame_number <= frame;
      req_frame_size_bytes <= size;
      req_samples_ok <= ok;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_cache(op, frame, size, ok);
      reqs_sent++;
   endtask

   // Lowers valid and waits until every expected result has been checked.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes happen only with the cache idle.
   task automatic write_csr(input logic idx, input logic [39:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == lcb_pkg::CSR_MAX_ENTRIES)
         lim_entries = value[4:0];
      else
         lim_bytes = value;
   endtask

   task automatic set_limits(input logic [4:0] entries, input logic [39:0] bytes);
      write_csr(lcb_pkg::CSR_MAX_ENTRIES, 40'(entries));
      write_csr(lcb_pkg::CSR_BYTE_BUDGET, bytes);
   endtask

   // Hits, misses, replacement, removal, refusals and clear at reset limits.
   task automatic test_basic_requests();
      send_req(lcb_pkg::REQ_PUT, 31'd5, 32'd100, 1'b1);
      send_req(lcb_pkg::REQ_GET, 31'd5, 32'd0, 1'b0);
      send_req(lcb_pkg::REQ_GET, 31'd9, 32'hFFFF_FFFF, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd5, 32'd300, 1'b1);
      send_req(lcb_pkg::REQ_REMOVE, 31'd5, 32'd0, 1'b0);
      send_req(lcb_pkg::REQ_REMOVE, 31'd5, 32'd0, 1'b0);
      send_req(lcb_pkg::REQ_PUT, 31'd6, 32'd10, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd6, 32'd50, 1'b0);
      send_req(lcb_pkg::REQ_PUT, 31'd7, 32'd0, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd8, 32'h1000_0001, 1'b1);
      send_req(lcb_pkg::REQ_CLEAR, 31'h7FFF_FFFF, 32'd0, 1'b0);
   endtask

   // Tight limits force evictions by entry count and by byte budget, and
   // a put exactly at the budget pushes everything else out.
   task automatic test_evictions();
      set_limits(5'd2, 40'd1000);
      send_req(lcb_pkg::REQ_PUT, 31'd1, 32'd400, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd2, 32'd400, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd3, 32'd400, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd4, 32'd1000, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd9, 32'd1001, 1'b1);
      send_req(lcb_pkg::REQ_GET, 31'd4, 32'd0, 1'b0);
   endtask

   // Field and register extremes, a limit above capacity, zero limits, and
   // a lowered limit that only takes effect on the next put.
   task automatic test_extremes();
      set_limits(5'd31, 40'hFF_FFFF_FFFF);
      send_req(lcb_pkg::REQ_PUT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_req(lcb_pkg::REQ_PUT, 31'd0, 32'hFFFF_FFFF, 1'b1);
      send_req(lcb_pkg::REQ_GET, 31'h7FFF_FFFF, 32'd0, 1'b0);
      send_req(lcb_pkg::REQ_PUT, 31'd77, 32'd1, 1'b1);
      write_csr(lcb_pkg::CSR_MAX_ENTRIES, 40'd1);
      send_req(lcb_pkg::REQ_GET, 31'd0, 32'd0, 1'b0);
      send_req(lcb_pkg::REQ_PUT, 31'd78, 32'd2, 1'b1);
      set_limits(5'd0, 40'd5000);
      send_req(lcb_pkg::REQ_PUT, 31'd79, 32'd3, 1'b1);
      set_limits(5'd16, 40'd0);
      send_req(lcb_pkg::REQ_PUT, 31'd78, 32'd3, 1'b1);
   endtask

   // Random requests over a small frame pool so that hits, replacements and
   // evictions are common, with some frames drawn from the full range.
   task automatic test_random_phase(input logic [4:0] entries, input logic [39:0] bytes,
                                    input int count);
      int pick;
      logic [1:0]  op;
      logic [30:0] frame;
      logic [31:0] size;
      logic [39:0] span;
      logic        ok;
      set_limits(entries, bytes);
      span = (bytes / 3 > 40'hFFFF_FFFF) ? 40'hFFFF_FFFF : bytes / 3;
      if (span == 0)
         span = 1;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         op = (pick < 48) ? lcb_pkg::REQ_PUT : (pick < 78) ? lcb_pkg::REQ_GET
            : (pick < 96) ? lcb_pkg::REQ_REMOVE : lcb_pkg::REQ_CLEAR;
         frame = ($urandom_range(0, 99) < 85) ? 31'($urandom_range(100, 111))
                                               : 31'($urandom);
         size = ($urandom_range(0, 99) < 85) ? 32'($urandom_range(1, 32'(span))) : $urandom;
         ok = ($urandom_range(0, 99) < 92);
         // Stretches with neither side idling.
         if (n % 10 == 0)
            no_idling = ($urandom_range(0, 3) == 0);
         send_req(op, frame, size, ok);
         // The sender sometimes waits until every result has come back.
         if (n == count / 2)
            drain_results();
      end
      no_idling = 1'b0;
   endtask

   // Result transactions: random stall, checked against the oldest expectation.
   int stall_left = 0;
   always @(posedge clock) begin
      cache_result_type e;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report($sformatf("unexpected result kind=%0d frame=%0d",
                                rsp_result_kind, rsp_result_frame));
            end else begin
               e = pending_results.pop_front();
               if (e.kind == lcb_pkg::KIND_EVICT)
                  evictions_seen++;
               if (e.kind == lcb_pkg::KIND_REFUSED)
                  refusals_seen++;
               if (rsp_result_kind !== e.kind)
                  report($sformatf("kind %0d, expected %0d", rsp_result_kind, e.kind));
               if (rsp_result_frame !== e.frame)
                  report($sformatf("frame %0d, expected %0d", rsp_result_frame, e.frame));
               if (rsp_found !== e.found)
                  report($sformatf("found %0b, expected %0b", rsp_found, e.found));
               if (rsp_resident_count !== e.count)
                  report($sformatf("count %0d, expected %0d", rsp_resident_count, e.count));
               if (rsp_resident_bytes !== e.bytes)
                  report($sformatf("bytes %0d, expected %0d", rsp_resident_bytes, e.bytes));
               if (rsp_last_result !== e.last)
                  report($sformatf("last %0b, expected %0b", rsp_last_result, e.last));
            end
            stall_left = draw_gap();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: too long without any accepted transaction ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      lim_entries = 5'd16;
      lim_bytes = 40'd268435456;
      held_bytes = '0;
      held_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_age[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_requests();
      test_evictions();
      test_extremes();
      test_random_phase(5'd16, 40'd268435456, 24);
      test_random_phase(5'd4, 40'd1500, 24);
      test_random_phase(5'd20, 40'hFF_FFFF_FFFF, 24);
      test_random_phase(5'd3, 40'd100000, 24);

      drain_results();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests and %0d results, %0d evictions and %0d refused puts,",
               reqs_sent, results_seen, evictions_seen, refusals_seen);
      $display("across entry limits 0 to 31 and byte budgets 0 to the 40-bit maximum.");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
